// ===== hdl/triangle_split_at_plane_assert.svh =====
// Assertion macros shared by the checker of triangle_split_at_plane.
`ifndef TRIANGLE_SPLIT_AT_PLANE_ASSERT_SVH
`define TRIANGLE_SPLIT_AT_PLANE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSAP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle_split_at_plane: check failed");

// Consequent must hold in the cycle after the antecedent.
`define TSAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle_split_at_plane: check failed");

`endif

// ===== hdl/tsap_pkg.sv =====
// Shared types, constants and codes of the triangle split block.
package tsap_pkg;

    localparam int VERT_W   = 21;
    localparam int IDX_W    = 22;
    localparam int HGT_W    = 32;
    localparam int CNT_W    = 21;
    localparam int STEP_W   = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [HGT_W-1:0] ZERO = '0;

    // Register codes, taken from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_ELEM_COUNT = 1'b1;

    localparam logic KIND_TRI  = 1'b0;
    localparam logic KIND_NODE = 1'b1;

    // Last step index of each record sequence
    localparam logic [STEP_W-1:0] LAST_STEP_PLAIN = 3'd0;
    localparam logic [STEP_W-1:0] LAST_STEP_ONE   = 3'd2;
    localparam logic [STEP_W-1:0] LAST_STEP_TWO   = 3'd4;

    typedef enum logic [2:0] {
        SPLIT_NONE,
        SPLIT_12_23,
        SPLIT_12_Z3,
        SPLIT_12_31,
        SPLIT_23_Z1,
        SPLIT_23_31,
        SPLIT_31_Z2
    } split_case_t;

    typedef struct packed {
        split_case_t              split;
        logic [VERT_W-1:0]        v1;
        logic [VERT_W-1:0]        v2;
        logic [VERT_W-1:0]        v3;
        logic signed [HGT_W-1:0]  h1;
        logic signed [HGT_W-1:0]  h2;
        logic signed [HGT_W-1:0]  h3;
        logic [CNT_W-1:0]         slot;
        logic [IDX_W-1:0]         na;
        logic [IDX_W-1:0]         nb;
        logic [IDX_W-1:0]         ea;
        logic [IDX_W-1:0]         eb;
    } job_t;

    typedef struct packed {
        logic                     kind;
        logic [IDX_W-1:0]         position;
        logic [IDX_W-1:0]         corner_a;
        logic [IDX_W-1:0]         corner_b;
        logic [IDX_W-1:0]         corner_c;
        logic signed [HGT_W-1:0]  weight_first;
        logic signed [HGT_W-1:0]  weight_second;
        logic                     last;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/triangle_split_at_plane.sv =====
// The queue entry and then the output register lie between an accepted item and its first record.
// Throughput: one record per cycle out of a single output register while rec_stall is low, so
// a triangle gives 1 record (no crossing), 3 records (one cut) or 5 records (two cuts); a job
// queue of QUEUE_DEPTH triangles lets the input run ahead of the output.
// Reset: clears both count registers, the element and added counters, the queue and the
// output valid; no clearing pass, so an item can be taken straight after reset.
module triangle_split_at_plane #(
    parameter int QUEUE_DEPTH = tsap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsap_pkg::APB_AW-1:0]       paddr,
    input  logic [tsap_pkg::APB_DW-1:0]       pwdata,
    output logic [tsap_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              tri_valid,
    output logic                              tri_stall,
    input  logic [tsap_pkg::VERT_W-1:0]       vert_one,
    input  logic [tsap_pkg::VERT_W-1:0]       vert_two,
    input  logic [tsap_pkg::VERT_W-1:0]       vert_three,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_one,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_two,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_three,
    output logic                              rec_valid,
    input  logic                              rec_stall,
    output logic                              kind,
    output logic [tsap_pkg::IDX_W-1:0]        position,
    output logic [tsap_pkg::IDX_W-1:0]        corner_a,
    output logic [tsap_pkg::IDX_W-1:0]        corner_b,
    output logic [tsap_pkg::IDX_W-1:0]        corner_c,
    output logic signed [tsap_pkg::HGT_W-1:0] weight_first,
    output logic signed [tsap_pkg::HGT_W-1:0] weight_second,
    output logic                              last
);

    logic [tsap_pkg::VERT_W-1:0] orig_node_count_reg, orig_node_count_next;
    logic [tsap_pkg::VERT_W-1:0] orig_elem_count_reg, orig_elem_count_next;
    logic                        cfg_write;
    logic                        reg_sel;

    logic                 push;
    logic                 pop;
    tsap_pkg::job_t       push_job;
    tsap_pkg::job_t       head_job;
    tsap_pkg::q_status_t  q_status;
    tsap_pkg::rec_t       rec;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        orig_node_count_next = orig_node_count_reg;
        orig_elem_count_next = orig_elem_count_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                tsap_pkg::REG_NODE_COUNT:
                    orig_node_count_next = pwdata[tsap_pkg::VERT_W-1:0];
                default:
                    orig_elem_count_next = pwdata[tsap_pkg::VERT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            tsap_pkg::REG_NODE_COUNT:
                prdata = tsap_pkg::APB_DW'(orig_node_count_reg);
            default:
                prdata = tsap_pkg::APB_DW'(orig_elem_count_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_node_count_reg <= '0;
            orig_elem_count_reg <= '0;
        end
        else
        begin
            orig_node_count_reg <= orig_node_count_next;
            orig_elem_count_reg <= orig_elem_count_next;
        end
    end

    tsap_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .orig_node_count (orig_node_count_reg),
        .orig_elem_count (orig_elem_count_reg),
        .tri_valid       (tri_valid),
        .tri_stall       (tri_stall),
        .vert_one        (vert_one),
        .vert_two        (vert_two),
        .vert_three      (vert_three),
        .height_one      (height_one),
        .height_two      (height_two),
        .height_three    (height_three),
        .q_status        (q_status),
        .push            (push),
        .job             (push_job)
    );

    tsap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    tsap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec)
    );

    assign kind          = rec.kind;
    assign position      = rec.position;
    assign corner_a      = rec.corner_a;
    assign corner_b      = rec.corner_b;
    assign corner_c      = rec.corner_c;
    assign weight_first  = rec.weight_first;
    assign weight_second = rec.weight_second;
    assign last          = rec.last;

endmodule

// ===== hdl/tsap_front.sv =====
// Front part: classifies each triangle and assigns new node and slot numbers.
module tsap_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tsap_pkg::VERT_W-1:0]   orig_node_count,
    input  logic [tsap_pkg::VERT_W-1:0]   orig_elem_count,
    input  logic                          tri_valid,
    output logic                          tri_stall,
    input  logic [tsap_pkg::VERT_W-1:0]   vert_one,
    input  logic [tsap_pkg::VERT_W-1:0]   vert_two,
    input  logic [tsap_pkg::VERT_W-1:0]   vert_three,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_one,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_two,
    input  logic signed [tsap_pkg::HGT_W-1:0] height_three,
    input  tsap_pkg::q_status_t           q_status,
    output logic                          push,
    output tsap_pkg::job_t                job
);

    logic [tsap_pkg::CNT_W-1:0] elem_counter_reg, elem_counter_next;
    logic [tsap_pkg::IDX_W-1:0] added_nodes_reg, added_nodes_next;
    logic [tsap_pkg::IDX_W-1:0] added_elems_reg, added_elems_next;

    logic nz1, nz2, nz3;
    logic c12, c23, c31;
    logic [tsap_pkg::IDX_W-1:0] node_base;
    logic [tsap_pkg::IDX_W-1:0] elem_base;
    logic [tsap_pkg::IDX_W-1:0] added;
    tsap_pkg::split_case_t split;

    assign tri_stall = q_status.full;
    assign push      = tri_valid && !q_status.full;

    assign nz1 = (height_one   != tsap_pkg::ZERO);
    assign nz2 = (height_two   != tsap_pkg::ZERO);
    assign nz3 = (height_three != tsap_pkg::ZERO);

    // Strictly opposite signs on both ends
    assign c12 = nz1 && nz2 && (height_one[tsap_pkg::HGT_W-1] != height_two[tsap_pkg::HGT_W-1]);
    assign c23 = nz2 && nz3 &&
                 (height_two[tsap_pkg::HGT_W-1] != height_three[tsap_pkg::HGT_W-1]);
    assign c31 = nz3 && nz1 &&
                 (height_three[tsap_pkg::HGT_W-1] != height_one[tsap_pkg::HGT_W-1]);

    always_comb
    begin
        priority if (c12 && c23)  split = tsap_pkg::SPLIT_12_23;
        else if (c12 && !nz3)     split = tsap_pkg::SPLIT_12_Z3;
        else if (c12 && c31)      split = tsap_pkg::SPLIT_12_31;
        else if (c23 && !nz1)     split = tsap_pkg::SPLIT_23_Z1;
        else if (c23 && c31)      split = tsap_pkg::SPLIT_23_31;
        else if (c31 && !nz2)     split = tsap_pkg::SPLIT_31_Z2;
        else                      split = tsap_pkg::SPLIT_NONE;
    end

    always_comb
    begin
        unique case (split)
            tsap_pkg::SPLIT_12_23,
            tsap_pkg::SPLIT_12_31,
            tsap_pkg::SPLIT_23_31: added = tsap_pkg::IDX_W'(2);
            tsap_pkg::SPLIT_12_Z3,
            tsap_pkg::SPLIT_23_Z1,
            tsap_pkg::SPLIT_31_Z2: added = tsap_pkg::IDX_W'(1);
            default:               added = '0;
        endcase
    end

    assign node_base = {1'b0, orig_node_count} + added_nodes_reg;
    assign elem_base = {1'b0, orig_elem_count} + added_elems_reg;

    always_comb
    begin
        job.split = split;
        job.v1    = vert_one;
        job.v2    = vert_two;
        job.v3    = vert_three;
        job.h1    = height_one;
        job.h2    = height_two;
        job.h3    = height_three;
        job.slot  = elem_counter_reg;
        job.na    = node_base + tsap_pkg::IDX_W'(1);
        job.nb    = node_base + tsap_pkg::IDX_W'(2);
        job.ea    = elem_base;
        job.eb    = elem_base + tsap_pkg::IDX_W'(1);
    end

    always_comb
    begin
        elem_counter_next = elem_counter_reg;
        added_nodes_next  = added_nodes_reg;
        added_elems_next  = added_elems_reg;
        if (push)
        begin
            elem_counter_next = elem_counter_reg + tsap_pkg::CNT_W'(1);
            added_nodes_next  = added_nodes_reg + added;
            added_elems_next  = added_elems_reg + added;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_counter_reg <= '0;
            added_nodes_reg  <= '0;
            added_elems_reg  <= '0;
        end
        else
        begin
            elem_counter_reg <= elem_counter_next;
            added_nodes_reg  <= added_nodes_next;
            added_elems_reg  <= added_elems_next;
        end
    end

endmodule

// ===== hdl/tsap_queue.sv =====
// Short job queue between the front and back parts.
module tsap_queue #(
    parameter int DEPTH = tsap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tsap_pkg::job_t       push_job,
    input  logic                 pop,
    output tsap_pkg::job_t       head_job,
    output tsap_pkg::q_status_t  q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tsap_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign head_job       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/tsap_back.sv =====
// Back part: steps through the records of each job into the output register.
module tsap_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsap_pkg::job_t       head_job,
    input  tsap_pkg::q_status_t  q_status,
    output logic                 pop,
    output logic                 rec_valid,
    input  logic                 rec_stall,
    output tsap_pkg::rec_t       rec
);

    logic [tsap_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        rec_valid_reg, rec_valid_next;
    tsap_pkg::rec_t              rec_reg;
    tsap_pkg::rec_t              cur_rec;
    logic [tsap_pkg::STEP_W-1:0] last_step;
    logic                        load;
    logic                        emit;

    logic [tsap_pkg::IDX_W-1:0] v1, v2, v3, slot;

    function automatic tsap_pkg::rec_t mk_tri(
        input logic [tsap_pkg::IDX_W-1:0] pos,
        input logic [tsap_pkg::IDX_W-1:0] a,
        input logic [tsap_pkg::IDX_W-1:0] b,
        input logic [tsap_pkg::IDX_W-1:0] c
    );
        tsap_pkg::rec_t r;
        r.kind          = tsap_pkg::KIND_TRI;
        r.position      = pos;
        r.corner_a      = a;
        r.corner_b      = b;
        r.corner_c      = c;
        r.weight_first  = tsap_pkg::ZERO;
        r.weight_second = tsap_pkg::ZERO;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic tsap_pkg::rec_t mk_node(
        input logic [tsap_pkg::IDX_W-1:0]     num,
        input logic [tsap_pkg::IDX_W-1:0]     a,
        input logic [tsap_pkg::IDX_W-1:0]     b,
        input logic signed [tsap_pkg::HGT_W-1:0] w1,
        input logic signed [tsap_pkg::HGT_W-1:0] w2
    );
        tsap_pkg::rec_t r;
        r.kind          = tsap_pkg::KIND_NODE;
        r.position      = num;
        r.corner_a      = a;
        r.corner_b      = b;
        r.corner_c      = '0;
        r.weight_first  = w1;
        r.weight_second = w2;
        r.last          = 1'b0;
        return r;
    endfunction

    assign v1   = {1'b0, head_job.v1};
    assign v2   = {1'b0, head_job.v2};
    assign v3   = {1'b0, head_job.v3};
    assign slot = {1'b0, head_job.slot};

    always_comb
    begin
        unique case (head_job.split)
            tsap_pkg::SPLIT_12_23,
            tsap_pkg::SPLIT_12_31,
            tsap_pkg::SPLIT_23_31: last_step = tsap_pkg::LAST_STEP_TWO;
            tsap_pkg::SPLIT_12_Z3,
            tsap_pkg::SPLIT_23_Z1,
            tsap_pkg::SPLIT_31_Z2: last_step = tsap_pkg::LAST_STEP_ONE;
            default:               last_step = tsap_pkg::LAST_STEP_PLAIN;
        endcase
    end

    // Pick the record for the current step of the head job
    always_comb
    begin
        cur_rec = mk_tri(slot, v1, v2, v3);
        unique case (head_job.split)
            tsap_pkg::SPLIT_12_23:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, head_job.na, v2, head_job.nb);
                    3'd1:    cur_rec = mk_tri(head_job.ea, v1, head_job.na, head_job.nb);
                    3'd2:    cur_rec = mk_tri(head_job.eb, v1, head_job.nb, v3);
                    3'd3:    cur_rec = mk_node(head_job.na, v1, v2, head_job.h2, head_job.h1);
                    default: cur_rec = mk_node(head_job.nb, v2, v3, head_job.h3, head_job.h2);
                endcase
            tsap_pkg::SPLIT_12_Z3:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, head_job.na, v2, v3);
                    3'd1:    cur_rec = mk_tri(head_job.ea, v1, head_job.na, v3);
                    default: cur_rec = mk_node(head_job.na, v1, v2, head_job.h2, head_job.h1);
                endcase
            tsap_pkg::SPLIT_12_31:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, v1, head_job.na, head_job.nb);
                    3'd1:    cur_rec = mk_tri(head_job.ea, head_job.na, v2, v3);
                    3'd2:    cur_rec = mk_tri(head_job.eb, head_job.na, v3, head_job.nb);
                    3'd3:    cur_rec = mk_node(head_job.na, v1, v2, head_job.h2, head_job.h1);
                    default: cur_rec = mk_node(head_job.nb, v3, v1, head_job.h1, head_job.h3);
                endcase
            tsap_pkg::SPLIT_23_Z1:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, v1, head_job.na, v3);
                    3'd1:    cur_rec = mk_tri(head_job.ea, head_job.na, v1, v2);
                    default: cur_rec = mk_node(head_job.na, v2, v3, head_job.h3, head_job.h2);
                endcase
            tsap_pkg::SPLIT_23_31:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, head_job.na, v3, head_job.nb);
                    3'd1:    cur_rec = mk_tri(head_job.ea, v1, v2, head_job.na);
                    3'd2:    cur_rec = mk_tri(head_job.eb, v1, head_job.na, head_job.nb);
                    3'd3:    cur_rec = mk_node(head_job.na, v2, v3, head_job.h3, head_job.h2);
                    default: cur_rec = mk_node(head_job.nb, v3, v1, head_job.h1, head_job.h3);
                endcase
            tsap_pkg::SPLIT_31_Z2:
                unique case (step_reg)
                    3'd0:    cur_rec = mk_tri(slot, head_job.na, v2, v3);
                    3'd1:    cur_rec = mk_tri(head_job.ea, v1, v2, head_job.na);
                    default: cur_rec = mk_node(head_job.na, v3, v1, head_job.h1, head_job.h3);
                endcase
            default:
                cur_rec = mk_tri(slot, v1, v2, v3);
        endcase
        cur_rec.last = (step_reg == last_step);
    end

    // Output register takes a new record whenever it is empty or being taken and the queue holds a job
    assign load = !rec_valid_reg || !rec_stall;
    assign emit = load && !q_status.empty;
    assign pop  = emit && (step_reg == last_step);

    always_comb
    begin
        step_next      = step_reg;
        rec_valid_next = rec_valid_reg;
        if (load)
            rec_valid_next = !q_status.empty;
        if (pop)
            step_next = '0;
        else if (emit)
            step_next = step_reg + tsap_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            rec_reg <= cur_rec;
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

endmodule

// ===== hdl/tsap_checker.sv =====
// Port-level checks of triangle_split_at_plane and their binding.
`include "triangle_split_at_plane_assert.svh"

module tsap_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rec_valid,
    input logic                              rec_stall,
    input logic                              kind,
    input logic [tsap_pkg::IDX_W-1:0]        position,
    input logic [tsap_pkg::IDX_W-1:0]        corner_a,
    input logic [tsap_pkg::IDX_W-1:0]        corner_b,
    input logic [tsap_pkg::IDX_W-1:0]        corner_c,
    input logic signed [tsap_pkg::HGT_W-1:0] weight_first,
    input logic signed [tsap_pkg::HGT_W-1:0] weight_second,
    input logic                              last
);

    tsap_pkg::rec_t rec_seen;
    logic           node_weights_ok;

    assign rec_seen = {kind, position, corner_a, corner_b, corner_c,
                       weight_first, weight_second, last};

    assign node_weights_ok = (weight_first != '0) && (weight_second != '0) &&
        (weight_first[tsap_pkg::HGT_W-1] != weight_second[tsap_pkg::HGT_W-1]);

    // Hold a stalled record unchanged
    `TSAP_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec_seen))

    // Node records carry no third corner
    `TSAP_ASSERT_SAME(a_node_corner, rec_valid && kind, corner_c == '0)

    // Triangle records carry no weights
    `TSAP_ASSERT_SAME(a_tri_weights, rec_valid && !kind, weight_first == '0 && weight_second == '0)

    // A new node sits on an edge whose end heights have strictly opposite sign
    `TSAP_ASSERT_SAME(a_node_cross, rec_valid && kind, node_weights_ok)

    // Node records close a split, so a triangle never follows a node within one item
    `TSAP_ASSERT_NEXT(a_node_order, rec_valid && !rec_stall && kind && !last, !rec_valid || kind)

endmodule

bind triangle_split_at_plane tsap_checker u_checker (.*);
